// ----- hdl/plic_pkg.sv -----
`timescale 1ns / 1ps

package plic_pkg;

    // default configuration
    localparam int NUM_SOURCES_DEF   = 32;
    localparam int NUM_CONTEXTS_DEF  = 2;
    localparam int PRIORITY_BITS_DEF = 3;

    // payload widths of the stream ports
    localparam int OP_W      = 2;
    localparam int ADDR_W    = 26;
    localparam int DATA_W    = 32;
    localparam int LEVELS_W  = 32;
    localparam int IRQ_W     = 2;
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 40;

    // register window
    localparam logic [ADDR_W-1:0] PENDING_BASE = 26'h000_1000;
    localparam logic [ADDR_W-1:0] ENABLE_BASE  = 26'h000_2000;
    localparam logic [ADDR_W-1:0] CONTEXT_BASE = 26'h020_0000;
    localparam logic [11:0]       THRESH_REG   = 12'h000;
    localparam logic [11:0]       CLAIM_REG    = 12'h004;
    localparam int                ENABLE_CTX_LSB  = 7;
    localparam int                CONTEXT_CTX_LSB = 12;

    typedef enum logic [OP_W-1:0] {
        OP_IDLE  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [ADDR_W-1:0]   addr;
        logic [DATA_W-1:0]   wdata;
        logic [LEVELS_W-1:0] levels;
    } bus_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] rdata;
        logic              err;
    } bus_rsp_t;

endpackage

// ----- hdl/plic_arbiter.sv -----
`timescale 1ns / 1ps

module plic_arbiter #(
    parameter int NUM_SOURCES   = plic_pkg::NUM_SOURCES_DEF,
    parameter int PRIORITY_BITS = plic_pkg::PRIORITY_BITS_DEF,
    localparam int ID_W         = $clog2(NUM_SOURCES)
) (
    input  logic [NUM_SOURCES-1:0]   pending,
    input  logic [NUM_SOURCES-1:0]   enable,
    input  logic [PRIORITY_BITS-1:0] prio [NUM_SOURCES],
    input  logic [PRIORITY_BITS-1:0] threshold,
    output logic                     found,
    output logic [ID_W-1:0]          id
);

    localparam int LEAVES = 1 << ID_W;
    localparam int NODES  = 2 * LEAVES - 1;

    logic                     node_vld [NODES];
    logic [PRIORITY_BITS-1:0] node_pri [NODES];
    logic [ID_W-1:0]          node_id  [NODES];

    // leaves sit in heap order, so the left child always has the lower ids
    for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
        if (i < NUM_SOURCES) begin : g_src
            assign node_vld[LEAVES-1+i] = pending[i] && enable[i] && (prio[i] > threshold);
            assign node_pri[LEAVES-1+i] = prio[i];
            assign node_id[LEAVES-1+i]  = ID_W'(i);
        end else begin : g_pad
            assign node_vld[LEAVES-1+i] = 1'b0;
            assign node_pri[LEAVES-1+i] = '0;
            assign node_id[LEAVES-1+i]  = '0;
        end
    end

    for (genvar k = 0; k < LEAVES - 1; k++) begin : g_node
        logic pick_right;
        // strict compare keeps ties on the lower id
        assign pick_right = node_vld[2*k+2] &&
                            (!node_vld[2*k+1] || (node_pri[2*k+2] > node_pri[2*k+1]));
        assign node_vld[k] = node_vld[2*k+1] || node_vld[2*k+2];
        assign node_pri[k] = pick_right ? node_pri[2*k+2] : node_pri[2*k+1];
        assign node_id[k]  = pick_right ? node_id[2*k+2]  : node_id[2*k+1];
    end

    assign found = node_vld[0];
    assign id    = node_vld[0] ? node_id[0] : '0;

endmodule

// ----- hdl/plic_regs.sv -----
`timescale 1ns / 1ps

module plic_regs #(
    parameter int NUM_SOURCES   = plic_pkg::NUM_SOURCES_DEF,
    parameter int NUM_CONTEXTS  = plic_pkg::NUM_CONTEXTS_DEF,
    parameter int PRIORITY_BITS = plic_pkg::PRIORITY_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        exec,
    input  plic_pkg::bus_req_t          req,
    output plic_pkg::bus_rsp_t          rsp,
    output logic [plic_pkg::IRQ_W-1:0]  irq
);

    localparam int NUM_WORDS = (NUM_SOURCES + 31) / 32;
    localparam int PAD_W     = NUM_WORDS * 32;
    localparam int ID_W      = $clog2(NUM_SOURCES);
    localparam int CTX_W     = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
    localparam int WORD_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int ADDR_W_L  = plic_pkg::ADDR_W;
    localparam logic [NUM_SOURCES-1:0] SRC_MASK = {{(NUM_SOURCES-1){1'b1}}, 1'b0};
    localparam logic [PAD_W-1:0]       SRC_MASK_PAD = PAD_W'(SRC_MASK);

    logic [PRIORITY_BITS-1:0] prio_reg    [NUM_SOURCES];
    logic [NUM_SOURCES-1:0]   pending_reg, pending_next;
    logic [NUM_SOURCES-1:0]   inflight_reg, inflight_next;
    logic [NUM_SOURCES-1:0]   enable_reg  [NUM_CONTEXTS];
    logic [PRIORITY_BITS-1:0] thresh_reg  [NUM_CONTEXTS];

    // address decode
    logic                  is_acc, is_wr, aligned;
    logic                  in_prio, in_pend, in_en, in_ctx;
    logic [20:0]           en_off;
    logic [ADDR_W_L-1:0]   cx_off;
    logic                  region_ok, err, acc_ok;
    logic [ID_W-1:0]       prio_idx;
    logic [WORD_W-1:0]     pend_word, en_word;
    logic [CTX_W-1:0]      en_ctx, cx_ctx;
    logic                  cx_is_thresh;

    logic [PAD_W-1:0]      pend_pad, en_pad, en_wr_pad, lines_pad;
    logic [NUM_SOURCES-1:0] lines;
    logic                  claim_found;
    logic [ID_W-1:0]       claim_id;
    logic [ID_W-1:0]       done_id;
    logic                  done_ok;
    logic [31:0]           rdata;

    always_comb begin
        is_acc  = exec && (req.op == plic_pkg::OP_READ || req.op == plic_pkg::OP_WRITE);
        is_wr   = (req.op == plic_pkg::OP_WRITE);
        aligned = (req.addr[1:0] == 2'b00);
        in_prio = (req.addr < plic_pkg::PENDING_BASE);
        in_pend = !in_prio && (req.addr < plic_pkg::ENABLE_BASE);
        in_en   = (req.addr >= plic_pkg::ENABLE_BASE) && (req.addr < plic_pkg::CONTEXT_BASE);
        in_ctx  = (req.addr >= plic_pkg::CONTEXT_BASE);
        en_off  = req.addr[20:0] - plic_pkg::ENABLE_BASE[20:0];
        cx_off  = req.addr - plic_pkg::CONTEXT_BASE;
        cx_is_thresh = (req.addr[11:0] == plic_pkg::THRESH_REG);

        region_ok = 1'b0;
        priority if (in_prio) begin
            region_ok = (32'(req.addr[11:2]) < 32'(NUM_SOURCES));
        end else if (in_pend) begin
            region_ok = (32'(req.addr[11:2]) < 32'(NUM_WORDS));
        end else if (in_en) begin
            region_ok = (32'(en_off[20:plic_pkg::ENABLE_CTX_LSB]) < 32'(NUM_CONTEXTS)) &&
                        (32'(en_off[6:2]) < 32'(NUM_WORDS));
        end else begin
            region_ok = (32'(cx_off[ADDR_W_L-1:plic_pkg::CONTEXT_CTX_LSB]) <
                         32'(NUM_CONTEXTS)) &&
                        (cx_is_thresh || req.addr[11:0] == plic_pkg::CLAIM_REG);
        end

        err    = is_acc && !(aligned && region_ok);
        acc_ok = is_acc && !err;

        prio_idx  = req.addr[ID_W+1:2];
        pend_word = req.addr[WORD_W+1:2];
        en_word   = en_off[WORD_W+1:2];
        // out-of-range contexts only matter on error paths; park them on context zero
        en_ctx    = (32'(en_off[20:plic_pkg::ENABLE_CTX_LSB]) < 32'(NUM_CONTEXTS))
                  ? en_off[CTX_W+plic_pkg::ENABLE_CTX_LSB-1:plic_pkg::ENABLE_CTX_LSB] : '0;
        cx_ctx    = (32'(cx_off[ADDR_W_L-1:plic_pkg::CONTEXT_CTX_LSB]) < 32'(NUM_CONTEXTS))
                  ? cx_off[CTX_W+plic_pkg::CONTEXT_CTX_LSB-1:plic_pkg::CONTEXT_CTX_LSB] : '0;
    end

    assign pend_pad  = PAD_W'(pending_reg);
    assign en_pad    = PAD_W'(enable_reg[en_ctx]);
    assign lines_pad = PAD_W'(req.levels);
    assign lines     = lines_pad[NUM_SOURCES-1:0];

    always_comb begin
        en_wr_pad = en_pad;
        en_wr_pad[32*en_word +: 32] = req.wdata & SRC_MASK_PAD[32*en_word +: 32];
    end

    plic_arbiter #(
        .NUM_SOURCES   (NUM_SOURCES),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_claim_arb (
        .pending   (pending_reg),
        .enable    (enable_reg[cx_ctx]),
        .prio      (prio_reg),
        .threshold (thresh_reg[cx_ctx]),
        .found     (claim_found),
        .id        (claim_id)
    );

    assign done_id = req.wdata[ID_W-1:0];
    assign done_ok = (req.wdata != 32'd0) && (req.wdata < 32'(NUM_SOURCES)) &&
                     inflight_reg[done_id] && enable_reg[cx_ctx][done_id];

    // bus access first, then the gateways sample the lines
    always_comb begin
        rdata         = '0;
        pending_next  = pending_reg;
        inflight_next = inflight_reg;
        if (acc_ok) begin
            priority if (in_prio) begin
                if (!is_wr) rdata = 32'(prio_reg[prio_idx]);
            end else if (in_pend) begin
                if (!is_wr) rdata = pend_pad[32*pend_word +: 32];
            end else if (in_en) begin
                if (!is_wr) rdata = en_pad[32*en_word +: 32];
            end else if (cx_is_thresh) begin
                if (!is_wr) rdata = 32'(thresh_reg[cx_ctx]);
            end else if (!is_wr) begin
                rdata = 32'(claim_id);
                if (claim_found) begin
                    pending_next[claim_id]  = 1'b0;
                    inflight_next[claim_id] = 1'b1;
                end
            end else begin
                if (done_ok) begin
                    inflight_next[done_id] = 1'b0;
                end
            end
        end
        if (exec) begin
            pending_next = pending_next | (lines & SRC_MASK & ~inflight_next);
        end
    end

    assign rsp.rdata = rdata;
    assign rsp.err   = err;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg  <= '0;
            inflight_reg <= '0;
            for (int i = 0; i < NUM_SOURCES; i++) begin
                prio_reg[i] <= '0;
            end
            for (int c = 0; c < NUM_CONTEXTS; c++) begin
                enable_reg[c] <= '0;
                thresh_reg[c] <= '0;
            end
        end else if (exec) begin
            pending_reg  <= pending_next;
            inflight_reg <= inflight_next;
            if (acc_ok && is_wr) begin
                if (in_prio) begin
                    if (prio_idx != '0) prio_reg[prio_idx] <= req.wdata[PRIORITY_BITS-1:0];
                end else if (in_en) begin
                    enable_reg[en_ctx] <= en_wr_pad[NUM_SOURCES-1:0];
                end else if (in_ctx && cx_is_thresh) begin
                    thresh_reg[cx_ctx] <= req.wdata[PRIORITY_BITS-1:0];
                end
            end
        end
    end

    // interrupt lines of the first contexts, from the state as it stands
    for (genvar c = 0; c < plic_pkg::IRQ_W; c++) begin : g_irq
        if (c < NUM_CONTEXTS) begin : g_ctx
            logic [ID_W-1:0] irq_id;
            plic_arbiter #(
                .NUM_SOURCES   (NUM_SOURCES),
                .PRIORITY_BITS (PRIORITY_BITS)
            ) u_irq_arb (
                .pending   (pending_reg),
                .enable    (enable_reg[c]),
                .prio      (prio_reg),
                .threshold (thresh_reg[c]),
                .found     (irq[c]),
                .id        (irq_id)
            );
        end else begin : g_none
            assign irq[c] = 1'b0;
        end
    end

endmodule

// ----- hdl/platform_interrupt_controller.sv -----
`timescale 1ns / 1ps

// Platform-level interrupt controller. Each transfer on the s_ side is one item: an idle
// tick, a 32-bit register read or a 32-bit register write (s_tuser), and it always carries
// the sampled source lines; each item yields exactly one m_ transfer with the read data,
// the access error flag and the interrupt lines of contexts 0 and 1 as they stand after the
// item. Window: 4*id priority, 0x1000 pending (read only), 0x2000 + 0x80*c enable,
// 0x200000 + 0x1000*c threshold, +4 claim/complete. A claim returns the enabled pending
// source of highest priority above the threshold, lowest id on a tie, or 0. One item is
// taken every cycle while the result side keeps up. An item passes the input register, then
// the register file update, then the result register that also takes the interrupt lines
// of the updated state and raises m_tvalid. A stalled result stalls the whole pipe and the
// input. The clock is bounded by the priority compare trees over all sources that serve the
// claim and the interrupt lines.
module platform_interrupt_controller #(
    parameter int NUM_SOURCES   = plic_pkg::NUM_SOURCES_DEF,
    parameter int NUM_CONTEXTS  = plic_pkg::NUM_CONTEXTS_DEF,
    parameter int PRIORITY_BITS = plic_pkg::PRIORITY_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // address [25:0], write_data [57:26], source_levels [89:58], zero fill
    input  logic [plic_pkg::S_TDATA_W-1:0]   s_tdata,
    // operation [1:0]
    input  logic [plic_pkg::OP_W-1:0]        s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // read_data [31:0], irq_out [33:32], access_error [34], zero fill
    output logic [plic_pkg::M_TDATA_W-1:0]   m_tdata
);

    logic                            adv;
    logic                            in_valid_reg;
    plic_pkg::bus_req_t              in_req_reg;
    logic                            mid_valid_reg;
    plic_pkg::bus_rsp_t              mid_rsp_reg;
    plic_pkg::bus_rsp_t              rsp;
    logic [plic_pkg::IRQ_W-1:0]      irq;
    logic                            out_valid_reg;
    plic_pkg::bus_rsp_t              out_rsp_reg;
    logic [plic_pkg::IRQ_W-1:0]      out_irq_reg;

    // the whole pipe moves together whenever the output slot is free
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            in_valid_reg  <= s_tvalid;
            mid_valid_reg <= in_valid_reg;
            out_valid_reg <= mid_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (s_tvalid) begin
                in_req_reg.op     <= plic_pkg::op_t'(s_tuser);
                in_req_reg.addr   <= s_tdata[25:0];
                in_req_reg.wdata  <= s_tdata[57:26];
                in_req_reg.levels <= s_tdata[89:58];
            end
            mid_rsp_reg <= rsp;
            out_rsp_reg <= mid_rsp_reg;
            // state now reflects exactly the item held in the middle stage
            out_irq_reg <= irq;
        end
    end

    plic_regs #(
        .NUM_SOURCES   (NUM_SOURCES),
        .NUM_CONTEXTS  (NUM_CONTEXTS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .exec    (adv && in_valid_reg),
        .req     (in_req_reg),
        .rsp     (rsp),
        .irq     (irq)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_rsp_reg.err, out_irq_reg, out_rsp_reg.rdata};

endmodule

// ----- hdl/plic_checker.sv -----
`timescale 1ns / 1ps

module plic_protocol_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [plic_pkg::M_TDATA_W-1:0] m_tdata
);

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result transfer offered right after reset");

    // a stalled result holds its data
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // a stalled result stalls the input side as well
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while the result slot is full");

    // an access error never returns data
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[34] |-> m_tdata[31:0] == 32'd0)
        else $error("read data returned on an access error");

endmodule

bind platform_interrupt_controller plic_protocol_checker u_plic_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- verif/plic_checker.sv -----
`timescale 1ns / 1ps

module plic_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // address [25:0], write_data [57:26], source_levels [89:58], zero fill
    input  logic [plic_pkg::S_TDATA_W-1:0] s_tdata,
    // operation [1:0]
    input  logic [plic_pkg::OP_W-1:0]      s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // read_data [31:0], irq_out [33:32], access_error [34], zero fill
    input  logic [plic_pkg::M_TDATA_W-1:0] m_tdata,
    output int                             mismatches,
    output int                             results_due
);

    localparam int NUM_SRC  = plic_pkg::NUM_SOURCES_DEF;
    localparam int NUM_CTX  = plic_pkg::NUM_CONTEXTS_DEF;
    localparam int PRIO_W   = plic_pkg::PRIORITY_BITS_DEF;
    localparam int OP_W     = plic_pkg::OP_W;
    localparam int ADDR_W   = plic_pkg::ADDR_W;
    localparam int DATA_W   = plic_pkg::DATA_W;
    localparam int LEVELS_W = plic_pkg::LEVELS_W;
    localparam int IRQ_W    = plic_pkg::IRQ_W;
    // source 0 has no gateway and no enable bit
    localparam logic [31:0] SOURCE_MASK = 32'hFFFF_FFFE;

    typedef struct packed {
        logic [DATA_W-1:0] rdata;
        logic [IRQ_W-1:0]  irq;
        logic              err;
    } plic_result_t;

    logic [PRIO_W-1:0] src_prio [NUM_SRC];
    logic [31:0]       pending_q;
    logic [31:0]       in_service_q;
    logic [31:0]       ctx_enable [NUM_CTX];
    logic [PRIO_W-1:0] ctx_threshold [NUM_CTX];
    plic_result_t      expected_q [$];

    // highest priority enabled pending source above threshold, lowest id wins a tie
    function automatic logic [4:0] winning_source(int ctx);
        logic [4:0]        best;
        logic [PRIO_W-1:0] best_prio;
        best = '0;
        best_prio = ctx_threshold[ctx];
        for (int id = 1; id < NUM_SRC; id++) begin
            if (pending_q[id] && ctx_enable[ctx][id] && src_prio[id] > best_prio) begin
                best = id[4:0];
                best_prio = src_prio[id];
            end
        end
        return best;
    endfunction

    // applies one bus item to the shadow registers and returns what the block must answer
    function automatic plic_result_t apply_bus_item(logic [OP_W-1:0] op, logic [ADDR_W-1:0] a,
                                                    logic [DATA_W-1:0] wd,
                                                    logic [LEVELS_W-1:0] lv);
        plic_result_t      res;
        logic              wr;
        logic [ADDR_W-1:0] off;
        int                id;
        int                ctx;
        logic [4:0]        pick;
        res = '0;
        wr = (op == plic_pkg::OP_WRITE);
        if (op == plic_pkg::OP_READ || op == plic_pkg::OP_WRITE) begin
            if (a[1:0] != 2'b00) begin
                res.err = 1'b1;
            end else if (a < plic_pkg::PENDING_BASE) begin
                id = int'(a >> 2);
                if (id >= NUM_SRC) res.err = 1'b1;
                else if (!wr) res.rdata = DATA_W'(src_prio[id]);
                else if (id != 0) src_prio[id] = wd[PRIO_W-1:0];
            end else if (a < plic_pkg::ENABLE_BASE) begin
                // single pending word, read only
                if (a != plic_pkg::PENDING_BASE) res.err = 1'b1;
                else if (!wr) res.rdata = pending_q;
            end else if (a < plic_pkg::CONTEXT_BASE) begin
                off = a - plic_pkg::ENABLE_BASE;
                ctx = int'(off >> plic_pkg::ENABLE_CTX_LSB);
                if (ctx >= NUM_CTX || off[plic_pkg::ENABLE_CTX_LSB-1:2] != '0) res.err = 1'b1;
                else if (!wr) res.rdata = ctx_enable[ctx];
                else ctx_enable[ctx] = wd & SOURCE_MASK;
            end else begin
                off = a - plic_pkg::CONTEXT_BASE;
                ctx = int'(off >> plic_pkg::CONTEXT_CTX_LSB);
                if (ctx >= NUM_CTX || (off[11:0] != plic_pkg::THRESH_REG &&
                                       off[11:0] != plic_pkg::CLAIM_REG)) begin
                    res.err = 1'b1;
                end else if (off[11:0] == plic_pkg::THRESH_REG) begin
                    if (!wr) res.rdata = DATA_W'(ctx_threshold[ctx]);
                    else ctx_threshold[ctx] = wd[PRIO_W-1:0];
                end else if (!wr) begin
                    pick = winning_source(ctx);
                    if (pick != '0) begin
                        pending_q[pick] = 1'b0;
                        in_service_q[pick] = 1'b1;
                    end
                    res.rdata = DATA_W'(pick);
                end else if (wd != '0 && wd < NUM_SRC && in_service_q[wd[4:0]]
                             && ctx_enable[ctx][wd[4:0]]) begin
                    in_service_q[wd[4:0]] = 1'b0;
                end
            end
        end
        // gateways sample after the bus access
        pending_q = pending_q | (lv & SOURCE_MASK & ~in_service_q);
        for (int c = 0; c < NUM_CTX && c < IRQ_W; c++)
            if (winning_source(c) != '0) res.irq[c] = 1'b1;
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s mismatch: got 0x%08h, expected 0x%08h", $time, field, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        plic_result_t want;
        if (!aresetn) begin
            foreach (src_prio[i]) src_prio[i] = '0;
            foreach (ctx_enable[i]) ctx_enable[i] = '0;
            foreach (ctx_threshold[i]) ctx_threshold[i] = '0;
            pending_q = '0;
            in_service_q = '0;
            expected_q.delete();
            mismatches = 0;
            results_due <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result transfer", m_tdata[31:0], '0);
                end else begin
                    want = expected_q.pop_front();
                    if (m_tdata[31:0] !== want.rdata)
                        report_mismatch("read_data", m_tdata[31:0], want.rdata);
                    if (m_tdata[33:32] !== want.irq)
                        report_mismatch("irq_out", 32'(m_tdata[33:32]), 32'(want.irq));
                    if (m_tdata[34] !== want.err)
                        report_mismatch("access_error", 32'(m_tdata[34]), 32'(want.err));
                end
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(apply_bus_item(s_tuser, s_tdata[25:0], s_tdata[57:26],
                                                    s_tdata[89:58]));
            results_due <= expected_q.size();
        end
    end

endmodule

// ----- verif/tb_platform_interrupt_controller.sv -----
`timescale 1ns / 1ps

module tb_platform_interrupt_controller;

    localparam int ADDR_W = plic_pkg::ADDR_W;
    localparam plic_pkg::op_t OP_RESERVED = plic_pkg::op_t'(2'd3);
    localparam int  CYCLE_LIMIT = 200000;
    localparam int  ITEMS_PER_PHASE = 400;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [plic_pkg::S_TDATA_W-1:0] s_tdata;
    logic [plic_pkg::OP_W-1:0]      s_tuser;
    logic                           m_tvalid;
    logic                           m_tready = 1'b1;
    logic [plic_pkg::M_TDATA_W-1:0] m_tdata;

    int mismatches;
    int results_due;
    int cycle_count = 0;
    int send_idle_pct = 7;
    int recv_idle_pct = 75;

    always #5 aclk = ~aclk;

    platform_interrupt_controller DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    plic_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .results_due (results_due)
    );

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("platform_interrupt_controller regression: fail");
            $finish;
        end
    end

    function automatic logic [ADDR_W-1:0] prio_addr(int id);
        return ADDR_W'(id) << 2;
    endfunction

    function automatic logic [ADDR_W-1:0] enable_addr(int ctx);
        return plic_pkg::ENABLE_BASE + (ADDR_W'(ctx) << plic_pkg::ENABLE_CTX_LSB);
    endfunction

    function automatic logic [ADDR_W-1:0] thresh_addr(int ctx);
        return plic_pkg::CONTEXT_BASE + (ADDR_W'(ctx) << plic_pkg::CONTEXT_CTX_LSB) +
               ADDR_W'(plic_pkg::THRESH_REG);
    endfunction

    function automatic logic [ADDR_W-1:0] claim_addr(int ctx);
        return plic_pkg::CONTEXT_BASE + (ADDR_W'(ctx) << plic_pkg::CONTEXT_CTX_LSB) +
               ADDR_W'(plic_pkg::CLAIM_REG);
    endfunction

    // holds the item until the block takes it, idling first at random
    task automatic push_item(plic_pkg::op_t op, logic [ADDR_W-1:0] a,
                             logic [plic_pkg::DATA_W-1:0] wd,
                             logic [plic_pkg::LEVELS_W-1:0] lv);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'b0, lv, wd, a};
        s_tuser <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic push_random_item();
        int                            kind;
        int                            ctx;
        plic_pkg::op_t                 op;
        logic [ADDR_W-1:0]             a;
        logic [plic_pkg::DATA_W-1:0]   wd;
        logic [plic_pkg::LEVELS_W-1:0] lv;
        kind = $urandom_range(0, 99);
        // mostly a context the block has, now and then one it lacks
        ctx = ($urandom_range(0, 19) == 0) ? $urandom_range(2, 3) : $urandom_range(0, 1);
        wd = $urandom;
        case ($urandom_range(0, 3))
            0: lv = '0;
            1: lv = $urandom;
            default: lv = $urandom & $urandom & $urandom;
        endcase
        if (kind < 10) begin
            op = plic_pkg::op_t'($urandom_range(0, 3));
            a = ADDR_W'($urandom);
            if ($urandom_range(0, 1) == 0) a[1:0] = 2'b00;
        end else if (kind < 25) begin
            op = plic_pkg::OP_WRITE;
            a = prio_addr($urandom_range(0, 31));
            if ($urandom_range(0, 1) == 0) wd = $urandom_range(0, 7);
        end else if (kind < 30) begin
            op = plic_pkg::OP_READ;
            a = prio_addr($urandom_range(0, 31));
        end else if (kind < 40) begin
            op = plic_pkg::OP_WRITE;
            a = enable_addr(ctx);
        end else if (kind < 43) begin
            op = plic_pkg::OP_READ;
            a = enable_addr(ctx);
        end else if (kind < 50) begin
            op = plic_pkg::OP_WRITE;
            a = thresh_addr(ctx);
            if ($urandom_range(0, 3) != 0) wd = $urandom_range(0, 3);
        end else if (kind < 53) begin
            op = plic_pkg::OP_READ;
            a = thresh_addr(ctx);
        end else if (kind < 73) begin
            op = plic_pkg::OP_READ;
            a = claim_addr(ctx);
        end else if (kind < 90) begin
            op = plic_pkg::OP_WRITE;
            a = claim_addr(ctx);
            if ($urandom_range(0, 9) != 0) wd = $urandom_range(1, 31);
        end else if (kind < 95) begin
            op = ($urandom_range(0, 3) == 0) ? plic_pkg::OP_WRITE : plic_pkg::OP_READ;
            a = plic_pkg::PENDING_BASE;
        end else begin
            op = plic_pkg::OP_IDLE;
            a = ADDR_W'($urandom);
        end
        push_item(op, a, wd, lv);
    endtask

    initial begin
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= plic_pkg::OP_IDLE;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: register extremes, claim/complete corner cases, bad addresses
        push_item(plic_pkg::OP_IDLE, '0, '0, '0);
        push_item(OP_RESERVED, claim_addr(0), 32'hFFFF_FFFF, '0);
        push_item(plic_pkg::OP_WRITE, prio_addr(0), 32'h7, '0);
        push_item(plic_pkg::OP_READ, prio_addr(0), '0, '0);
        push_item(plic_pkg::OP_WRITE, prio_addr(5), 32'hFFFF_FFFF, '0);
        push_item(plic_pkg::OP_WRITE, prio_addr(31), 32'h3, '0);
        push_item(plic_pkg::OP_WRITE, prio_addr(9), 32'h7, '0);
        push_item(plic_pkg::OP_WRITE, enable_addr(0), 32'hFFFF_FFFF, '0);
        push_item(plic_pkg::OP_WRITE, enable_addr(1), 32'h8000_0200, '0);
        push_item(plic_pkg::OP_WRITE, thresh_addr(1), 32'hFFFF_FFFA, '0);
        push_item(plic_pkg::OP_IDLE, '0, '0, 32'hFFFF_FFFF);
        push_item(plic_pkg::OP_READ, plic_pkg::PENDING_BASE, '0, '0);
        push_item(plic_pkg::OP_WRITE, plic_pkg::PENDING_BASE, '0, '0);
        // tie between sources 5 and 9 goes to 5
        push_item(plic_pkg::OP_READ, claim_addr(0), '0, '0);
        push_item(plic_pkg::OP_READ, claim_addr(1), '0, '0);
        push_item(plic_pkg::OP_READ, claim_addr(1), '0, '0);
        // nothing left above threshold
        push_item(plic_pkg::OP_READ, claim_addr(1), '0, '0);
        push_item(plic_pkg::OP_WRITE, claim_addr(0), 32'd31, 32'h8000_0000);
        // source 5 is not enabled for context 1
        push_item(plic_pkg::OP_WRITE, claim_addr(1), 32'd5, '0);
        push_item(plic_pkg::OP_WRITE, claim_addr(0), 32'hFFFF_FFFF, '0);
        push_item(plic_pkg::OP_READ, claim_addr(0) + 26'd2, '0, '0);
        push_item(plic_pkg::OP_READ, prio_addr(32), '0, '0);
        push_item(plic_pkg::OP_READ, plic_pkg::ENABLE_BASE + 26'h4, '0, '0);
        push_item(plic_pkg::OP_WRITE, thresh_addr(2), 32'h1, '0);
        push_item(plic_pkg::OP_READ, plic_pkg::CONTEXT_BASE + 26'h8, '0, '0);
        push_item(plic_pkg::OP_WRITE, 26'h3FF_FFFF, 32'hFFFF_FFFF, '0);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 7;
                    recv_idle_pct = 75;
                end
                1: begin
                    send_idle_pct = 75;
                    recv_idle_pct = 7;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            repeat (ITEMS_PER_PHASE) push_random_item();
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("platform_interrupt_controller regression: pass");
        end else begin
            $display("platform_interrupt_controller regression: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/plic_pkg.sv
hdl/plic_arbiter.sv
hdl/plic_regs.sv
hdl/platform_interrupt_controller.sv
hdl/plic_checker.sv
verif/plic_checker.sv
verif/tb_platform_interrupt_controller.sv
